@@ sv/drbm_pkg.sv @@
`default_nettype none

package drbm_pkg;

  // Tile geometry and map depth
  localparam int TILE_SIZE = 16;     // power of two, tile edge in pixels
  localparam int MAX_TILES = 8192;   // entries of the dirty map

  localparam int TileShift = $clog2(TILE_SIZE);
  localparam int AddrW     = $clog2(MAX_TILES);
  localparam int NumW      = 17;     // holds any tile number and MAX_TILES itself

  // Field widths
  localparam int CmdW     = 2;
  localparam int CoordW   = 16;
  localparam int LenW     = 16;
  localparam int IdxW     = 13;
  localparam int OrgW     = 15;
  localparam int GridW    = 9;
  localparam int TileW    = 8;       // tile row or column number, 0..255
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  // Offset from the area origin: signed, covers x + w - 1 - left
  localparam int OffW  = CoordW + 2;
  localparam int QuotW = OffW - 1 - TileShift;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] CFG_AREA_LEFT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AREA_TOP     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TILES_ACROSS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TILES_DOWN   = 3'd3;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_CLEAR,
    S_OFFS,
    S_BOUND,
    S_BASE,
    S_MARK,
    S_READ,
    S_RDATA,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_step;
    logic calc_offs;
    logic calc_bound;
    logic calc_base;
    logic mark_step;
    logic rd_issue;
    logic rd_latch;
    logic out_load;
  } drbm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero_size;
    logic clr_last;
    logic mark_last;
  } drbm_stat_t;

  // Last usable tile number for a grid size register (0 acts as 1, above 256 as 256)
  function automatic logic [TileW-1:0] grid_last(input logic [GridW-1:0] v);
    logic [GridW-1:0] m;
    m = v - GridW'(1);
    if (v == '0) begin
      return '0;
    end else if (v > GridW'(256)) begin
      return '1;
    end else begin
      return m[TileW-1:0];
    end
  endfunction

  // Pixel offset to tile number, saturated to 0..last
  function automatic logic [TileW-1:0] tile_of(input logic signed [OffW-1:0] off,
                                                input logic [TileW-1:0] last);
    logic [QuotW-1:0] q;
    q = off[OffW-2:TileShift];
    if (off[OffW-1]) begin
      return '0;
    end else if (q > QuotW'(last)) begin
      return last;
    end else begin
      return q[TileW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/drbm_ram.sv @@
`default_nettype none

module drbm_ram #(
  parameter int Width = 1,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/drbm_ctrl.sv @@
`default_nettype none

module drbm_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [drbm_pkg::CmdW-1:0]   command_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output drbm_pkg::drbm_cmd_t              cmd_o,
  input  wire drbm_pkg::drbm_stat_t        stat_i
);
  import drbm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_INIT_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (command_i)
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_MARK:  state_d = S_OFFS;
            CMD_READ:  state_d = S_READ;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      S_OFFS: begin
        cmd_o.calc_offs = 1'b1;
        state_d = stat_i.zero_size ? S_DONE : S_BOUND;
      end
      S_BOUND: begin
        cmd_o.calc_bound = 1'b1;
        state_d = S_BASE;
      end
      S_BASE: begin
        cmd_o.calc_base = 1'b1;
        state_d = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (stat_i.mark_last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_RDATA;
      end
      S_RDATA: begin
        cmd_o.rd_latch = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/drbm_dpath.sv @@
`default_nettype none

module drbm_dpath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic        [drbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [drbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic signed [drbm_pkg::CoordW-1:0]   rect_x_i,
  input  wire logic signed [drbm_pkg::CoordW-1:0]   rect_y_i,
  input  wire logic        [drbm_pkg::LenW-1:0]     rect_width_i,
  input  wire logic        [drbm_pkg::LenW-1:0]     rect_height_i,
  input  wire logic        [drbm_pkg::IdxW-1:0]     tile_index_i,
  input  wire drbm_pkg::drbm_cmd_t                  cmd_i,
  output drbm_pkg::drbm_stat_t                      stat_o,
  output logic                                      tile_dirty_o
);
  import drbm_pkg::*;

  // Configuration
  logic [OrgW-1:0]  area_left_q, area_top_q;
  logic [GridW-1:0] across_cfg_q, down_cfg_q;

  // Captured transaction
  logic signed [CoordW-1:0] x_q, y_q;
  logic [LenW-1:0]          w_q, h_q;
  logic [IdxW-1:0]          idx_q;

  // Mark walk
  logic signed [OffW-1:0] xo0_q, xo1_q, yo0_q, yo1_q;
  logic [TileW-1:0]       c0_q, c1_q, r0_q, r1_q, cur_c_q, cur_r_q;
  logic [NumW-1:0]        row_base_q;

  logic [AddrW-1:0] clr_cnt_q;
  logic             res_q, tile_dirty_q;

  logic [TileW-1:0] across_last, down_last;
  logic [GridW-1:0] across;
  logic [NumW-1:0]  tile_num, idx_ext;
  logic             wr_ok, idx_ok;
  logic             ram_we, ram_rdata;
  logic [AddrW-1:0] ram_waddr;

  assign across_last = grid_last(across_cfg_q);
  assign down_last   = grid_last(down_cfg_q);
  assign across      = GridW'(across_last) + GridW'(1);

  assign tile_num = row_base_q + NumW'(cur_c_q);
  assign wr_ok    = tile_num < NumW'(MAX_TILES);
  assign idx_ext  = NumW'(idx_q);
  assign idx_ok   = idx_ext < NumW'(MAX_TILES);

  assign stat_o.zero_size = (w_q == '0) || (h_q == '0);
  assign stat_o.clr_last  = clr_cnt_q == AddrW'(MAX_TILES - 1);
  assign stat_o.mark_last = (cur_c_q == c1_q) && (cur_r_q == r1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q  <= '0;
      area_top_q   <= '0;
      across_cfg_q <= GridW'(120);
      down_cfg_q   <= GridW'(68);
      clr_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AREA_LEFT:    area_left_q  <= cfg_wdata_i[OrgW-1:0];
          CFG_AREA_TOP:     area_top_q   <= cfg_wdata_i[OrgW-1:0];
          CFG_TILES_ACROSS: across_cfg_q <= cfg_wdata_i[GridW-1:0];
          CFG_TILES_DOWN:   down_cfg_q   <= cfg_wdata_i[GridW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= stat_o.clr_last ? '0 : clr_cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= rect_x_i;
      y_q   <= rect_y_i;
      w_q   <= rect_width_i;
      h_q   <= rect_height_i;
      idx_q <= tile_index_i;
      res_q <= 1'b0;
    end
    if (cmd_i.calc_offs) begin
      xo0_q <= OffW'(x_q) - OffW'(area_left_q);
      xo1_q <= OffW'(x_q) + OffW'(w_q) - OffW'(area_left_q) - OffW'(1);
      yo0_q <= OffW'(y_q) - OffW'(area_top_q);
      yo1_q <= OffW'(y_q) + OffW'(h_q) - OffW'(area_top_q) - OffW'(1);
    end
    if (cmd_i.calc_bound) begin
      c0_q <= tile_of(xo0_q, across_last);
      c1_q <= tile_of(xo1_q, across_last);
      r0_q <= tile_of(yo0_q, down_last);
      r1_q <= tile_of(yo1_q, down_last);
    end
    if (cmd_i.calc_base) begin
      row_base_q <= NumW'(r0_q * across);
      cur_c_q    <= c0_q;
      cur_r_q    <= r0_q;
    end
    if (cmd_i.mark_step) begin
      if (cur_c_q == c1_q) begin
        cur_c_q    <= c0_q;
        cur_r_q    <= cur_r_q + TileW'(1);
        row_base_q <= row_base_q + NumW'(across);
      end else begin
        cur_c_q <= cur_c_q + TileW'(1);
      end
    end
    if (cmd_i.rd_latch) begin
      res_q <= ram_rdata & idx_ok;
    end
    if (cmd_i.out_load) begin
      tile_dirty_q <= res_q;
    end
  end

  // Clear sweep writes zeros, mark walk writes ones
  assign ram_we    = cmd_i.clr_step || (cmd_i.mark_step && wr_ok);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : tile_num[AddrW-1:0];

  drbm_ram #(
    .Width (1),
    .Depth (MAX_TILES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.mark_step),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_ext[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign tile_dirty_o = tile_dirty_q;

endmodule

`default_nettype wire

@@ sv/damage_rect_block_marker_top.sv @@
// Dirty tile bitmap over a capture area, one bit per 16x16 pixel tile, 8192
// tiles. Each input transaction carries a command: clear wipes the map, mark
// sets every tile touched by one rectangle (offset by area_left/area_top,
// tile range saturated to the tiles_across x tiles_down grid), read returns
// the bit at tile_index. Every transaction gives exactly one output
// transaction; tile_dirty is 0 for anything but a read. One transaction is in
// work at a time. A read passes through issue and latch steps; an unused
// command goes straight to its result; a zero-size mark stops after the offset
// step; a mark runs offset, bound and base setup, then walks covered tiles
// as the map memory takes one tile write per cycle; clear sweeps the map one
// entry per cycle. After reset the same sweep runs first: in_stall_o stays
// high throughout (config writes are taken meanwhile). A new transaction may
// be taken while the previous result still waits on out_stall_i.
`default_nettype none

module damage_rect_block_marker_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic        [drbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [drbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  // command channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic        [drbm_pkg::CmdW-1:0]     command_i,
  input  wire logic signed [drbm_pkg::CoordW-1:0]   rect_x_i,
  input  wire logic signed [drbm_pkg::CoordW-1:0]   rect_y_i,
  input  wire logic        [drbm_pkg::LenW-1:0]     rect_width_i,
  input  wire logic        [drbm_pkg::LenW-1:0]     rect_height_i,
  input  wire logic        [drbm_pkg::IdxW-1:0]     tile_index_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      tile_dirty_o
);
  import drbm_pkg::*;

  drbm_cmd_t  cmd;
  drbm_stat_t stat;

  // Sequencer: clear sweep, offset/bound/base setup, tile walk, read, result hand-off
  drbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Config registers, rectangle-to-tile math, walk counters and the map memory
  drbm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .tile_index_i  (tile_index_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .tile_dirty_o  (tile_dirty_o)
  );

endmodule

`default_nettype wire

@@ sv/drbm_checker.sv @@
`default_nettype none

module drbm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic tile_dirty_o
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // transactions taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending_q <= pending_q + 2'd1;
        2'b01:   pending_q <= pending_q - 2'd1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tile_dirty_o))
    else $error("stalled result dropped or changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("command taken while previous one still in work");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result shown with no transaction outstanding");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pending_q != 2'd2 && pending_q != 2'd3)
    else $error("more than two transactions outstanding");

endmodule

bind damage_rect_block_marker_top drbm_checker u_drbm_checker (.*);

`default_nettype wire

@@ bench/drbm_bitmap_check.sv @@
`timescale 1ns / 100ps

module drbm_bitmap_check (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [drbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [drbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_stall_i,
  input  wire logic        [drbm_pkg::CmdW-1:0]     command_i,
  input  wire logic signed [drbm_pkg::CoordW-1:0]   rect_x_i,
  input  wire logic signed [drbm_pkg::CoordW-1:0]   rect_y_i,
  input  wire logic        [drbm_pkg::LenW-1:0]     rect_width_i,
  input  wire logic        [drbm_pkg::LenW-1:0]     rect_height_i,
  input  wire logic        [drbm_pkg::IdxW-1:0]     tile_index_i,
  input  wire logic                                 out_valid_i,
  input  wire logic                                 out_stall_i,
  input  wire logic                                 tile_dirty_i,
  output int                                        fail_count_o,
  output int                                        pending_o
);
  import drbm_pkg::*;

  localparam logic [GridW-1:0] RESET_ACROSS = 9'd120;
  localparam logic [GridW-1:0] RESET_DOWN   = 9'd68;

  logic [MAX_TILES-1:0] dirty_bits;
  logic [OrgW-1:0]      org_left;
  logic [OrgW-1:0]      org_top;
  logic [GridW-1:0]     grid_across;
  logic [GridW-1:0]     grid_down;
  logic                 expected_dirty_q[$];
  logic                 want_dirty;

  // 0 behaves as 1, anything above 256 as 256
  function automatic int unsigned grid_size(input logic [GridW-1:0] v);
    if (v == '0) return 1;
    if (v > GridW'(256)) return 256;
    return int'(v);
  endfunction

  function automatic int unsigned tile_at(input longint off, input int unsigned count);
    longint t;
    if (off < 0) return 0;
    t = off / TILE_SIZE;
    if (t > longint'(count) - 1) t = longint'(count) - 1;
    return int'(t);
  endfunction

  task automatic mark_rectangle(input logic signed [CoordW-1:0] x, y,
                                input logic [LenW-1:0] w, h);
    int unsigned across, down, c0, c1, r0, r1, r, c, n;
    across = grid_size(grid_across);
    down   = grid_size(grid_down);
    if (w == '0 || h == '0) return;
    c0 = tile_at(longint'(x) - longint'(org_left), across);
    c1 = tile_at(longint'(x) + longint'(w) - 1 - longint'(org_left), across);
    r0 = tile_at(longint'(y) - longint'(org_top), down);
    r1 = tile_at(longint'(y) + longint'(h) - 1 - longint'(org_top), down);
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        n = r * across + c;
        // tiles past the end of the map are dropped
        if (n < MAX_TILES) dirty_bits[n] = 1'b1;
      end
    end
  endtask

  task automatic apply_command(input logic [CmdW-1:0] cmd,
                               input logic signed [CoordW-1:0] x, y,
                               input logic [LenW-1:0] w, h,
                               input logic [IdxW-1:0] idx,
                               output logic dirty);
    dirty = 1'b0;
    case (cmd)
      CMD_CLEAR: dirty_bits = '0;
      CMD_MARK:  mark_rectangle(x, y, w, h);
      CMD_READ:  dirty = dirty_bits[idx];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_bits   = '0;
      org_left     = '0;
      org_top      = '0;
      grid_across  = RESET_ACROSS;
      grid_down    = RESET_DOWN;
      expected_dirty_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AREA_LEFT:    org_left    = cfg_wdata_i[OrgW-1:0];
          CFG_AREA_TOP:     org_top     = cfg_wdata_i[OrgW-1:0];
          CFG_TILES_ACROSS: grid_across = cfg_wdata_i[GridW-1:0];
          CFG_TILES_DOWN:   grid_down   = cfg_wdata_i[GridW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_dirty_q.size() == 0) begin
          $error("tile_dirty: result with no transaction outstanding, actual %0b",
                 tile_dirty_i);
          fail_count_o++;
        end else begin
          want_dirty = expected_dirty_q.pop_front();
          if (tile_dirty_i !== want_dirty) begin
            $error("tile_dirty: expected %0b, actual %0b", want_dirty, tile_dirty_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_command(command_i, rect_x_i, rect_y_i, rect_width_i, rect_height_i,
                      tile_index_i, want_dirty);
        expected_dirty_q.push_back(want_dirty);
      end
      pending_o = expected_dirty_q.size();
    end
  end

endmodule

@@ bench/tb_damage_rect_block_marker_top.sv @@
`timescale 1ns / 100ps

module tb_damage_rect_block_marker_top;
  import drbm_pkg::*;

  // Command code 3 is undefined; the block must ignore it and return 0.
  localparam logic [CmdW-1:0]    CMD_UNUSED      = 2'd3;
  // Register indexes 4..7 select nothing.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_BASE = 3'd4;

  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 62;
  localparam int LONG_HOLD         = 400;
  localparam int DRAIN_CYCLES      = 64;
  // Slowest expected run: ~15 clears, a handful of full-grid marks, the sweep
  // after reset, and ~520 short transactions stretched by stalls; the limit
  // leaves a wide margin above that.
  localparam int RUN_LIMIT         = 5_000_000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CfgIdxW-1:0]       cfg_idx;
  logic [CfgDataW-1:0]      cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [CmdW-1:0]          command;
  logic signed [CoordW-1:0] rect_x;
  logic signed [CoordW-1:0] rect_y;
  logic [LenW-1:0]          rect_width;
  logic [LenW-1:0]          rect_height;
  logic [IdxW-1:0]          tile_index;
  logic                     out_valid;
  logic                     out_stall;
  logic                     tile_dirty;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Idle rates in percent, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Raised once by the stimulus; the receiver process runs the hold itself.
  logic want_hold = 1'b0;

  // Effective area geometry as last programmed, used to aim rectangles.
  int cur_left   = 0;
  int cur_top    = 0;
  int cur_across = 120;
  int cur_down   = 68;

  always #5 clk_i = ~clk_i;

  damage_rect_block_marker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .rect_x_i      (rect_x),
    .rect_y_i      (rect_y),
    .rect_width_i  (rect_width),
    .rect_height_i (rect_height),
    .tile_index_i  (tile_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .tile_dirty_o  (tile_dirty)
  );

  drbm_bitmap_check u_bitmap_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .command_i     (command),
    .rect_x_i      (rect_x),
    .rect_y_i      (rect_y),
    .rect_width_i  (rect_width),
    .rect_height_i (rect_height),
    .tile_index_i  (tile_index),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .tile_dirty_i  (tile_dirty),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_damage_rect_block_marker_top NOT OK");
      $finish;
    end
  end

  // Result side: random stalls at the phase's rate, plus one long hold-off so
  // the block backs up and has to stall its input.
  initial begin
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (want_hold && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so back-to-back transactions need no gap.
  task automatic offer_item(input logic [CmdW-1:0] cmd,
                            input logic signed [CoordW-1:0] x, y,
                            input logic [LenW-1:0] w, h,
                            input logic [IdxW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid    = 1'b1;
    command     = cmd;
    rect_x      = x;
    rect_y      = y;
    rect_width  = w;
    rect_height = h;
    tile_index  = idx;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register writes go in only once every result is back, so no transaction
  // is in work (the post-reset sweep may still run). Tile count registers get
  // junk in the unused data bits, and an unused index is hit every time.
  task automatic program_area(input logic [OrgW-1:0] left, top,
                              input logic [GridW-1:0] across, down);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = CFG_AREA_LEFT;
    cfg_wdata = left;
    @(negedge clk_i);
    cfg_idx   = CFG_AREA_TOP;
    cfg_wdata = top;
    @(negedge clk_i);
    cfg_idx   = CFG_TILES_ACROSS;
    cfg_wdata = {(CfgDataW-GridW)'($urandom), across};
    @(negedge clk_i);
    cfg_idx   = CFG_TILES_DOWN;
    cfg_wdata = {(CfgDataW-GridW)'($urandom), down};
    @(negedge clk_i);
    cfg_idx   = CFG_UNUSED_BASE + CfgIdxW'($urandom_range(3));
    cfg_wdata = CfgDataW'($urandom);
    @(negedge clk_i);
    cfg_we     = 1'b0;
    cur_left   = int'(left);
    cur_top    = int'(top);
    cur_across = (across == '0) ? 1 : (across > GridW'(256)) ? 256 : int'(across);
    cur_down   = (down == '0) ? 1 : (down > GridW'(256)) ? 256 : int'(down);
  endtask

  // One random transaction. Most marks land inside the area with small sizes,
  // some straddle an edge, some are pure noise; a rare few keep fully random
  // sizes, mostly huge. Half the reads aim at tiles inside the grid.
  task automatic random_item();
    int                       pick, shape, aw, ah, row, col, n;
    logic [CmdW-1:0]          cmd;
    logic signed [CoordW-1:0] x, y;
    logic [LenW-1:0]          w, h;
    logic [IdxW-1:0]          idx;
    pick = $urandom_range(99);
    x    = CoordW'($urandom);
    y    = CoordW'($urandom);
    w    = LenW'($urandom);
    h    = LenW'($urandom);
    idx  = IdxW'($urandom);
    aw   = cur_across * TILE_SIZE;
    ah   = cur_down * TILE_SIZE;
    if (pick < 3) begin
      cmd = CMD_CLEAR;
    end else if (pick < 8) begin
      cmd = CMD_UNUSED;
    end else if (pick < 52) begin
      cmd = CMD_READ;
      if ($urandom_range(1) == 1) begin
        row = $urandom_range(cur_down - 1);
        col = $urandom_range(cur_across - 1);
        n   = row * cur_across + col;
        if (n < MAX_TILES) idx = IdxW'(n);
      end
    end else begin
      cmd   = CMD_MARK;
      shape = $urandom_range(99);
      if (shape < 70) begin
        x = CoordW'(cur_left + $urandom_range(aw - 1));
        y = CoordW'(cur_top + $urandom_range(ah - 1));
        w = LenW'($urandom_range(3 * TILE_SIZE, 1));
        h = LenW'($urandom_range(3 * TILE_SIZE, 1));
      end else if (shape < 85) begin
        // hang over the origin or over the far edge
        if ($urandom_range(1) == 1) begin
          x = CoordW'(cur_left - $urandom_range(2 * TILE_SIZE, 1));
          y = CoordW'(cur_top - $urandom_range(2 * TILE_SIZE, 1));
        end else begin
          x = CoordW'(cur_left + aw - $urandom_range(TILE_SIZE, 1));
          y = CoordW'(cur_top + ah - $urandom_range(TILE_SIZE, 1));
        end
        w = LenW'($urandom_range(4 * TILE_SIZE, 1));
        h = LenW'($urandom_range(4 * TILE_SIZE, 1));
      end else if (shape < 98) begin
        w = LenW'($urandom_range(64));
        h = LenW'($urandom_range(64));
      end
      // else: huge, full random sizes stay
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1) == 1) w = '0;
        else h = '0;
      end
    end
    offer_item(cmd, x, y, w, h, idx);
  endtask

  initial begin
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    command     = CMD_CLEAR;
    rect_x      = '0;
    rect_y      = '0;
    rect_width  = '0;
    rect_height = '0;
    tile_index  = '0;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 64;

    // Directed part. Registers go in while the post-reset sweep still runs.
    program_area(15'd40, 15'd24, 9'd120, 9'd68);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd0);             // fresh map reads 0
    offer_item(CMD_MARK, 16'sd40, 16'sd24, 16'd1, 16'd1, '0); // single pixel, tile 0
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd0);
    // zero width, then zero height: nothing marked at tile 2
    offer_item(CMD_MARK, 16'sd72, 16'sd24, 16'd0, 16'd10, '0);
    offer_item(CMD_MARK, 16'sd72, 16'sd24, 16'd10, 16'd0, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd2);
    // entirely left of and above the origin: saturates to tile 0
    offer_item(CMD_MARK, 16'sh8000, 16'sh8000, 16'd20, 16'd20, '0);
    // from the far corner outward: saturates to the last tile
    offer_item(CMD_MARK, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd8159);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'h1FFF);
    offer_item(CMD_UNUSED, 16'shFFFF, 16'shFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
    // covers the whole 120 x 68 grid
    offer_item(CMD_MARK, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd8000);
    offer_item(CMD_CLEAR, '0, '0, '0, '0, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd8159);

    // Largest origin and grid; rows from 32 on fall outside the map.
    program_area(15'h7FFF, 15'h7FFF, 9'd256, 9'd256);
    offer_item(CMD_MARK, 16'sh7FFF, 16'sh7FFF, 16'd16, 16'd16, '0);
    offer_item(CMD_MARK, 16'sh7FFF, 16'sh7FFF, 16'd1, 16'hFFFF, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd7936);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'h1FFF);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd1);

    // Zero-sized grid acts as a single tile.
    program_area(15'd0, 15'd0, 9'd0, 9'd0);
    offer_item(CMD_MARK, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd1);

    // Oversized grid registers clamp to 256.
    program_area(15'd0, 15'd0, 9'h1FF, 9'd300);
    offer_item(CMD_MARK, 16'sd0, 16'sd0, 16'h1000, 16'h0100, '0);
    offer_item(CMD_READ, '0, '0, '0, '0, 13'd4095);

    // Random part: one area setting per block of transactions. Settings 0-2
    // stall mostly on the result side, 3-5 mostly on the command side, 6-7
    // run flat out, with the long hold-off at the start of 6.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: program_area(15'd0, 15'd0, 9'd120, 9'd68);
        1: program_area(OrgW'($urandom_range(2000)), OrgW'($urandom_range(2000)),
                        GridW'($urandom_range(256, 1)), GridW'($urandom_range(256, 1)));
        2: program_area(15'h7FFF, 15'h7FFF, 9'd256, 9'd256);
        3: program_area(15'd0, 15'd0, 9'd0, 9'd0);
        4: program_area(OrgW'($urandom_range(2000)), OrgW'($urandom_range(2000)),
                        9'h1FF, 9'd300);
        5: program_area(15'd100, 15'd200, 9'd256, 9'd40);
        6: program_area(OrgW'($urandom_range(500)), OrgW'($urandom_range(500)),
                        GridW'($urandom), GridW'($urandom));
        default: program_area(OrgW'($urandom), OrgW'($urandom),
                              GridW'($urandom), GridW'($urandom));
      endcase
      if (s < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 64;
      end else if (s < 6) begin
        send_idle_pct = 64;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (s == 6) want_hold = 1'b1;
      repeat (ITEMS_PER_SETTING) random_item();
    end

    // Drain: every result back, then a quiet stretch to catch stray results.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_damage_rect_block_marker_top OK");
    end else begin
      $display("tb_damage_rect_block_marker_top NOT OK");
    end
    $finish;
  end

endmodule

@@ damage_rect_block_marker_top.f @@
sv/drbm_pkg.sv
sv/drbm_ram.sv
sv/drbm_ctrl.sv
sv/drbm_dpath.sv
sv/damage_rect_block_marker_top.sv
sv/drbm_checker.sv
bench/drbm_bitmap_check.sv
bench/tb_damage_rect_block_marker_top.sv
